// ===== hw/rtl/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// shared types and constants for the button click event detector
// ----------------------------------------------------------------------------
package bce_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned THR_W = 16;
	localparam int unsigned CNT_W = 2;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [CNT_W-1:0] CLICKS_FOR_DOUBLE = CNT_W'(2);

	localparam logic [THR_W-1:0] BOUNCE_RST = THR_W'(50);
	localparam logic [THR_W-1:0] DOUBLE_CLICK_RST = THR_W'(300);
	localparam logic [THR_W-1:0] INACTIVITY_RST = THR_W'(5000);
	localparam logic [THR_W-1:0] HOLD_RST = THR_W'(1000);

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_BOUNCE = 2'd0,
		REG_DOUBLE_CLICK = 2'd1,
		REG_INACTIVITY = 2'd2,
		REG_HOLD = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0] bounce_ms;
		logic [THR_W-1:0] double_click_ms;
		logic [THR_W-1:0] inactivity_ms;
		logic [THR_W-1:0] hold_ms;
	} cfg_t;

	typedef struct packed {
		logic press;
		logic click;
		logic double_click;
		logic inactive;
		logic held;
	} evt_t;

endpackage

// ===== hw/rtl/bce_regs.sv =====
// ----------------------------------------------------------------------------
// bce_regs
// apb register file holding the four threshold registers
// ----------------------------------------------------------------------------
module bce_regs
	import bce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bounce_ms       <= BOUNCE_RST;
			cfg_q.double_click_ms <= DOUBLE_CLICK_RST;
			cfg_q.inactivity_ms   <= INACTIVITY_RST;
			cfg_q.hold_ms         <= HOLD_RST;
		end else if (wr_en) begin
			case (idx)
				REG_BOUNCE:       cfg_q.bounce_ms       <= pwdata[THR_W-1:0];
				REG_DOUBLE_CLICK: cfg_q.double_click_ms <= pwdata[THR_W-1:0];
				REG_INACTIVITY:   cfg_q.inactivity_ms   <= pwdata[THR_W-1:0];
				REG_HOLD:         cfg_q.hold_ms         <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_BOUNCE:       prdata = PDATA_W'(cfg_q.bounce_ms);
			REG_DOUBLE_CLICK: prdata = PDATA_W'(cfg_q.double_click_ms);
			REG_INACTIVITY:   prdata = PDATA_W'(cfg_q.inactivity_ms);
			REG_HOLD:         prdata = PDATA_W'(cfg_q.hold_ms);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/bce_core.sv =====
// ----------------------------------------------------------------------------
// bce_core
// button state, threshold flags and event logic for one poll
// ----------------------------------------------------------------------------
module bce_core
	import bce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              pin_level,
	input  cfg_t              cfg,
	output evt_t              evt
);

	logic              stable_level_q;
	logic [TIME_W-1:0] change_time_q;
	logic              change_seen_q;
	logic              bounce_flag_q;
	logic              window_flag_q;
	logic              idle_flag_q;
	logic              hold_flag_q;
	logic [CNT_W-1:0]  click_count_q;

	logic [TIME_W-1:0] elapsed;
	logic              changed;
	logic              level_nxt;
	logic              seen_nxt;
	logic              released;
	logic              b, w, i, h;
	logic [CNT_W-1:0]  cnt_win;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_nxt;

	assign elapsed   = now_ms - change_time_q;
	assign changed   = pin_level != stable_level_q;
	assign level_nxt = pin_level;
	assign seen_nxt  = change_seen_q || changed;
	assign released  = level_nxt;

	assign b = elapsed > TIME_W'(cfg.bounce_ms);
	assign w = elapsed > TIME_W'(cfg.double_click_ms);
	assign i = elapsed > TIME_W'(cfg.inactivity_ms);
	assign h = elapsed > TIME_W'(cfg.hold_ms);

	// window edge is handled before the press count
	assign cnt_win = (w && !window_flag_q) ? '0 : click_count_q;
	assign cnt_inc = cnt_win + CNT_W'(1);

	always_comb begin
		evt              = '0;
		cnt_nxt          = cnt_win;
		evt.press        = b && !bounce_flag_q && !released;
		evt.click        = b && !bounce_flag_q && released && seen_nxt;
		evt.inactive     = i && !idle_flag_q && released && seen_nxt;
		evt.held         = h && !hold_flag_q && !released && seen_nxt;
		if (evt.press) begin
			if (cnt_inc == CLICKS_FOR_DOUBLE) begin
				cnt_nxt          = '0;
				evt.double_click = 1'b1;
			end else begin
				cnt_nxt = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_level_q <= 1'b1;
			change_time_q  <= '0;
			change_seen_q  <= 1'b0;
			bounce_flag_q  <= 1'b0;
			window_flag_q  <= 1'b0;
			idle_flag_q    <= 1'b0;
			hold_flag_q    <= 1'b0;
			click_count_q  <= '0;
		end else if (step) begin
			stable_level_q <= level_nxt;
			if (changed) begin
				change_time_q <= now_ms;
			end
			change_seen_q <= seen_nxt;
			bounce_flag_q <= b;
			window_flag_q <= w;
			idle_flag_q   <= i;
			hold_flag_q   <= h;
			click_count_q <= cnt_nxt;
		end
	end

	a_double_has_press: assert property (@(posedge clk) disable iff (!arst_n)
		evt.double_click |-> evt.press)
		else $error("double click without press");

	a_press_click_excl: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (!(evt.press && evt.click) && !(evt.inactive && evt.held)))
		else $error("events for both levels in one poll");

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		change_seen_q |=> change_seen_q)
		else $error("change seen flag cleared");

	a_count_below_double: assert property (@(posedge clk) disable iff (!arst_n)
		click_count_q != CLICKS_FOR_DOUBLE)
		else $error("click count left at double");

endmodule

// ===== hw/rtl/button_click_event_detector.sv =====
// ----------------------------------------------------------------------------
// button_click_event_detector
// debounced press, click, double click, inactivity and hold detection
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    now_ms[31:0], pin_level
// out       output     out_valid / out_ready  press, click, double_click,
//                                             inactive, held
// apb       input      psel, penable, pready  paddr[3:0], pwdata, prdata
//
// each poll passes through the input register and then the result register;
// one transfer per cycle sustained while the output is not stalled
// button state updates as the poll moves from the input to the result register
// a stalled output holds the result register; the input register still takes
// a transfer when the result moves on in the same cycle
// reset clears the button state and loads the threshold defaults
//
module button_click_event_detector
	import bce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// poll channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TIME_W-1:0]  now_ms,
	input  logic               pin_level,
	// event channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               press,
	output logic               click,
	output logic               double_click,
	output logic               inactive,
	output logic               held,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t              cfg;
	evt_t              evt;

	// input register
	logic              v_s1;
	logic [TIME_W-1:0] now_s1;
	logic              pin_s1;

	// result register
	logic              v_s2;
	evt_t              evt_s2;

	logic              adv;
	logic              take;

	// poll moves on when the result register is free or being drained
	assign adv      = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv;
	assign take     = in_valid && in_ready;

	bce_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bce_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.now_ms    (now_s1),
		.pin_level (pin_s1),
		.cfg       (cfg),
		.evt       (evt)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			now_s1 <= now_ms;
			pin_s1 <= pin_level;
		end
		if (adv) begin
			evt_s2 <= evt;
		end
	end

	assign out_valid    = v_s2;
	assign press        = evt_s2.press;
	assign click        = evt_s2.click;
	assign double_click = evt_s2.double_click;
	assign inactive     = evt_s2.inactive;
	assign held         = evt_s2.held;

endmodule
